@@ design/sdh_pkg.sv @@
// Shared types, codes and helper functions for the SD card SPI host engine.
// No dependencies; every other design file but sdh_if refers to it by scoped names.
`default_nettype none
package sdh_pkg;

	localparam int BLOCK_BYTES = 512;
	localparam int Q_DEPTH     = 8;

	// Input operation codes
	localparam logic [1:0] OP_REQUEST = 2'd0;
	localparam logic [1:0] OP_RXBYTE  = 2'd1;
	localparam logic [1:0] OP_TICK    = 2'd2;
	localparam logic [1:0] OP_WRBYTE  = 2'd3;

	// Request codes
	localparam logic [2:0] REQ_INIT  = 3'd0;
	localparam logic [2:0] REQ_READ  = 3'd1;
	localparam logic [2:0] REQ_WRITE = 3'd2;
	localparam logic [2:0] REQ_SYNC  = 3'd3;
	localparam logic [2:0] REQ_CAP   = 3'd4;

	// Result kinds
	localparam logic [1:0] KIND_TX   = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_NEED = 2'd2;
	localparam logic [1:0] KIND_DONE = 2'd3;

	// Card types
	localparam logic [2:0] CT_NONE   = 3'd0;
	localparam logic [2:0] CT_MMC    = 3'd1;
	localparam logic [2:0] CT_SD1    = 3'd2;
	localparam logic [2:0] CT_SD2B   = 3'd3;
	localparam logic [2:0] CT_SD2BLK = 3'd4;

	// Configuration register indexes
	localparam logic [2:0] CFG_R1_RETRY   = 3'd0;
	localparam logic [2:0] CFG_INIT_TO    = 3'd1;
	localparam logic [2:0] CFG_READY_TO   = 3'd2;
	localparam logic [2:0] CFG_TOKEN_TO   = 3'd3;
	localparam logic [2:0] CFG_WRITE_TO   = 3'd4;
	localparam logic [2:0] CFG_WAKE_BYTES = 3'd5;

	// Command bytes (bit 7 marks an application command)
	localparam logic [7:0] CMD_GO_IDLE  = 8'd0;
	localparam logic [7:0] CMD_OP_MMC   = 8'd1;
	localparam logic [7:0] CMD_IF_COND  = 8'd8;
	localparam logic [7:0] CMD_SEND_CSD = 8'd9;
	localparam logic [7:0] CMD_BLOCKLEN = 8'd16;
	localparam logic [7:0] CMD_READ1    = 8'd17;
	localparam logic [7:0] CMD_WRITE1   = 8'd24;
	localparam logic [7:0] CMD_READ_OCR = 8'd58;
	localparam logic [7:0] ACMD_OP_COND = 8'h80 | 8'd41;
	localparam logic [5:0] CMD_APP      = 6'd55;

	localparam logic [7:0]  CRC_CMD0    = 8'h95;
	localparam logic [7:0]  CRC_CMD8    = 8'h87;
	localparam logic [7:0]  CRC_DUMMY   = 8'h01;
	localparam logic [31:0] IF_COND_ARG = 32'h0000_01AA;
	localparam logic [31:0] HCS_ARG     = 32'h4000_0000;
	localparam logic [7:0]  TOKEN_START = 8'hFE;
	localparam logic [7:0]  RESP_OK     = 8'h05;
	localparam logic [7:0]  IDLE_BYTE   = 8'hFF;

	typedef enum logic [4:0] {
		PH_IDLE, PH_WAKE, PH_CDESEL, PH_CSEL, PH_CWAIT, PH_CFAIL, PH_CFRAME, PH_CR1,
		PH_R7, PH_OCR, PH_DDONE, PH_TOKEN, PH_RDATA, PH_RCRC, PH_WREADY, PH_WTOKEN,
		PH_WNEED, PH_WDATA, PH_WCRC, PH_WRESP, PH_WFINAL, PH_SSEL, PH_SWAIT, PH_SFAIL
	} phase_t;

	typedef enum logic [3:0] {
		K_CMD0, K_CMD8, K_A41V2, K_CMD58, K_PROBE, K_POLL1, K_CMD16,
		K_CMD17, K_CMD24, K_CMD9
	} cont_t;

	typedef enum logic [2:0] {
		ACT_NONE, ACT_SEND, ACT_ISSUE, ACT_FINISH, ACT_FINISH_INIT, ACT_DONE,
		ACT_WEND, ACT_NEED
	} act_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  request;
		logic [31:0] start_sector;
		logic [15:0] block_count;
		logic [7:0]  rx_byte;
		logic [7:0]  write_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx_byte;
		logic        chip_select_n;
		logic        fast_clock;
		logic [7:0]  data_byte;
		logic        last;
		logic        status;
		logic [2:0]  card_type;
		logic [31:0] sector_count;
	} res_t;

	typedef struct packed {
		logic [7:0]  r1_retry_limit;
		logic [15:0] init_timeout_ms;
		logic [15:0] ready_timeout_ms;
		logic [15:0] token_timeout_ms;
		logic [15:0] write_timeout_ms;
		logic [7:0]  wake_byte_count;
	} cfg_t;

	// Byte i of a command frame: start+index, 4 argument bytes, CRC
	function automatic logic [7:0] frame_byte(input logic in_app, input logic [7:0] cmd,
			input logic [31:0] arg, input logic [2:0] i);
		logic [5:0]  idx;
		logic [31:0] a;
		logic [7:0]  b;
		idx = in_app ? CMD_APP : cmd[5:0];
		a   = in_app ? 32'd0 : arg;
		case (i)
			3'd0: b = 8'h40 | {2'b00, idx};
			3'd1: b = a[31:24];
			3'd2: b = a[23:16];
			3'd3: b = a[15:8];
			3'd4: b = a[7:0];
			default: begin
				if (idx == CMD_GO_IDLE[5:0]) b = CRC_CMD0;
				else if (idx == CMD_IF_COND[5:0]) b = CRC_CMD8;
				else b = CRC_DUMMY;
			end
		endcase
		return b;
	endfunction

	// Sector count from a CSD register (v2 layout when structure is 1, else v1)
	function automatic logic [31:0] decode_csd(input logic [15:0][7:0] c);
		logic [21:0] sz2;
		logic [11:0] sz1;
		logic [4:0]  e;
		logic [31:0] m;
		sz2 = {c[7][5:0], c[8], c[9]};
		sz1 = {c[6][1:0], c[7], c[8][7:6]};
		e   = 5'(c[5][3:0]) + 5'({c[9][1:0], c[10][7]}) + 5'd2;
		m   = 32'(sz1) + 32'd1;
		if (c[0][7:6] == 2'd1) return (32'(sz2) + 32'd1) << 10;
		if (e >= 5'd9) return m << (e - 5'd9);
		return m >> (5'd9 - e);
	endfunction

endpackage
`default_nettype wire

@@ design/sdh_if.sv @@
// Valid/ready channel interfaces for the engine's input items and results.
// No dependencies; the field widths are fixed here to match sdh_pkg.
`default_nettype none
interface sdh_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [2:0]  request;
	logic [31:0] start_sector;
	logic [15:0] block_count;
	logic [7:0]  rx_byte;
	logic [7:0]  write_byte;
	modport source (output valid, op, request, start_sector, block_count, rx_byte,
		write_byte, input ready);
	modport sink (input valid, op, request, start_sector, block_count, rx_byte,
		write_byte, output ready);
endinterface

interface sdh_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  tx_byte;
	logic        chip_select_n;
	logic        fast_clock;
	logic [7:0]  data_byte;
	logic        last;
	logic        status;
	logic [2:0]  card_type;
	logic [31:0] sector_count;
	modport source (output valid, kind, tx_byte, chip_select_n, fast_clock, data_byte,
		last, status, card_type, sector_count, input ready);
	modport sink (input valid, kind, tx_byte, chip_select_n, fast_clock, data_byte,
		last, status, card_type, sector_count, output ready);
endinterface
`default_nettype wire

@@ design/sdh_engine.sv @@
// Sequencer state and the one-pass step logic: one registered item in, up to two results out.
// Depends on sdh_pkg.
`default_nettype none
module sdh_engine (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	input  wire sdh_pkg::item_t  item,
	input  wire sdh_pkg::cfg_t   cfg,
	output logic [1:0]           res_cnt,
	output sdh_pkg::res_t        res0,
	output sdh_pkg::res_t        res1
);

	sdh_pkg::phase_t phase_q, n_phase;
	sdh_pkg::cont_t  cont_q, n_cont;
	logic [2:0]  card_kind_q, n_card_kind, new_kind_q, n_new_kind, req_q, n_req;
	logic        ready_q, n_ready, speed_q, n_speed, in_app_q, n_in_app;
	logic        cs_n_q, n_cs_n, op_ok_q, n_op_ok;
	logic [7:0]  retry_q, n_retry, pending_q, n_pending, poll_cmd_q, n_poll_cmd;
	logic [15:0] elapsed_q, n_elapsed, init_ms_q, n_init_ms, blocks_q, n_blocks;
	logic [9:0]  bi_q, n_bi;
	logic [31:0] cur_q, n_cur, arg_q, n_arg, cap_q, n_cap;
	logic [3:0][7:0]  reply_q, n_reply;
	logic [15:0][7:0] csd_q, n_csd;

	sdh_pkg::act_t  act;
	sdh_pkg::cont_t act_k;
	logic [7:0]  act_tx, act_cmd, ret_r1;
	logic [31:0] act_arg;
	logic        act_last, do_ret, pre_valid;
	sdh_pkg::res_t pre_res, act_res;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sdh_pkg::PH_IDLE;
			cont_q <= sdh_pkg::K_CMD0;
			card_kind_q <= sdh_pkg::CT_NONE;
			new_kind_q <= sdh_pkg::CT_NONE;
			req_q <= '0;
			ready_q <= 1'b0;
			speed_q <= 1'b0;
			in_app_q <= 1'b0;
			cs_n_q <= 1'b1;
			op_ok_q <= 1'b0;
			retry_q <= '0;
			pending_q <= '0;
			poll_cmd_q <= '0;
			elapsed_q <= '0;
			init_ms_q <= '0;
			blocks_q <= '0;
			bi_q <= '0;
			cur_q <= '0;
			arg_q <= '0;
			cap_q <= '0;
		end else begin
			phase_q <= n_phase;
			cont_q <= n_cont;
			card_kind_q <= n_card_kind;
			new_kind_q <= n_new_kind;
			req_q <= n_req;
			ready_q <= n_ready;
			speed_q <= n_speed;
			in_app_q <= n_in_app;
			cs_n_q <= n_cs_n;
			op_ok_q <= n_op_ok;
			retry_q <= n_retry;
			pending_q <= n_pending;
			poll_cmd_q <= n_poll_cmd;
			elapsed_q <= n_elapsed;
			init_ms_q <= n_init_ms;
			blocks_q <= n_blocks;
			bi_q <= n_bi;
			cur_q <= n_cur;
			arg_q <= n_arg;
			cap_q <= n_cap;
		end
	end

	// Reply and CSD byte stores
	always_ff @(posedge clk) begin
		reply_q <= n_reply;
		csd_q <= n_csd;
	end

	// Step logic: pick an action per phase, then apply it
	always_comb begin
		n_phase = phase_q; n_cont = cont_q; n_card_kind = card_kind_q;
		n_new_kind = new_kind_q; n_req = req_q; n_ready = ready_q; n_speed = speed_q;
		n_in_app = in_app_q; n_cs_n = cs_n_q; n_op_ok = op_ok_q; n_retry = retry_q;
		n_pending = pending_q; n_poll_cmd = poll_cmd_q; n_elapsed = elapsed_q;
		n_init_ms = init_ms_q; n_blocks = blocks_q; n_bi = bi_q; n_cur = cur_q;
		n_arg = arg_q; n_cap = cap_q; n_reply = reply_q; n_csd = csd_q;
		act = sdh_pkg::ACT_NONE; act_tx = sdh_pkg::IDLE_BYTE; act_cmd = '0; act_arg = '0;
		act_k = sdh_pkg::K_CMD0; act_last = 1'b0; do_ret = 1'b0; ret_r1 = sdh_pkg::IDLE_BYTE;
		pre_valid = 1'b0; pre_res = '0; act_res = '0;

		if (item_valid) begin
			case (item.op)
				sdh_pkg::OP_REQUEST: begin
					if (phase_q == sdh_pkg::PH_IDLE) begin
						n_req = item.request;
						n_op_ok = 1'b0;
						n_cap = '0;
						if (item.request == sdh_pkg::REQ_INIT) begin
							n_ready = 1'b0; n_card_kind = sdh_pkg::CT_NONE; n_speed = 1'b0;
							n_new_kind = sdh_pkg::CT_NONE; n_cs_n = 1'b1; n_bi = '0;
							if (cfg.wake_byte_count == 8'd0) begin
								act = sdh_pkg::ACT_ISSUE; act_cmd = sdh_pkg::CMD_GO_IDLE;
								act_k = sdh_pkg::K_CMD0;
							end else begin
								n_phase = sdh_pkg::PH_WAKE; act = sdh_pkg::ACT_SEND;
							end
						end else if (item.request > sdh_pkg::REQ_CAP || !ready_q) begin
							act = sdh_pkg::ACT_DONE;
						end else begin
							n_cur = item.start_sector;
							n_blocks = item.block_count;
							case (item.request)
								sdh_pkg::REQ_READ: begin
									if (n_blocks == '0) begin
										n_op_ok = 1'b1; act = sdh_pkg::ACT_FINISH;
									end else begin
										act = sdh_pkg::ACT_ISSUE; act_cmd = sdh_pkg::CMD_READ1;
										act_k = sdh_pkg::K_CMD17;
										act_arg = (card_kind_q == sdh_pkg::CT_SD2BLK) ? n_cur
											: (n_cur << 9);
									end
								end
								sdh_pkg::REQ_WRITE: begin
									if (n_blocks == '0) act = sdh_pkg::ACT_WEND;
									else begin
										act = sdh_pkg::ACT_ISSUE; act_cmd = sdh_pkg::CMD_WRITE1;
										act_k = sdh_pkg::K_CMD24;
										act_arg = (card_kind_q == sdh_pkg::CT_SD2BLK) ? n_cur
											: (n_cur << 9);
									end
								end
								sdh_pkg::REQ_CAP: begin
									act = sdh_pkg::ACT_ISSUE; act_cmd = sdh_pkg::CMD_SEND_CSD;
									act_k = sdh_pkg::K_CMD9;
								end
								default: begin
									n_cs_n = 1'b0; n_phase = sdh_pkg::PH_SSEL;
									act = sdh_pkg::ACT_SEND;
								end
							endcase
						end
					end
				end
				sdh_pkg::OP_TICK: begin
					if (elapsed_q != 16'hFFFF) n_elapsed = elapsed_q + 16'd1;
					if (init_ms_q != 16'hFFFF) n_init_ms = init_ms_q + 16'd1;
				end
				sdh_pkg::OP_WRBYTE: begin
					if (phase_q == sdh_pkg::PH_WNEED) begin
						n_phase = sdh_pkg::PH_WDATA;
						act = sdh_pkg::ACT_SEND; act_tx = item.write_byte;
					end
				end
				default: begin
					// card byte
					case (phase_q)
						sdh_pkg::PH_WAKE: begin
							n_bi = bi_q + 10'd1;
							if (n_bi < {2'b00, cfg.wake_byte_count}) act = sdh_pkg::ACT_SEND;
							else begin
								act = sdh_pkg::ACT_ISSUE; act_cmd = sdh_pkg::CMD_GO_IDLE;
								act_k = sdh_pkg::K_CMD0;
							end
						end
						sdh_pkg::PH_CDESEL: begin
							n_cs_n = 1'b0; n_phase = sdh_pkg::PH_CSEL; act = sdh_pkg::ACT_SEND;
						end
						sdh_pkg::PH_CSEL: begin
							n_elapsed = '0; n_phase = sdh_pkg::PH_CWAIT; act = sdh_pkg::ACT_SEND;
						end
						sdh_pkg::PH_CWAIT: begin
							act = sdh_pkg::ACT_SEND;
							if (item.rx_byte == sdh_pkg::IDLE_BYTE) begin
								n_bi = '0; n_phase = sdh_pkg::PH_CFRAME;
								act_tx = sdh_pkg::frame_byte(in_app_q, pending_q, arg_q, 3'd0);
							end else if (!(elapsed_q < cfg.ready_timeout_ms)) begin
								n_cs_n = 1'b1; n_phase = sdh_pkg::PH_CFAIL;
							end
						end
						sdh_pkg::PH_CFAIL: begin
							do_ret = 1'b1; ret_r1 = sdh_pkg::IDLE_BYTE;
						end
						sdh_pkg::PH_CFRAME: begin
							n_bi = bi_q + 10'd1;
							act = sdh_pkg::ACT_SEND;
							if (n_bi < 10'd6) begin
								act_tx = sdh_pkg::frame_byte(in_app_q, pending_q, arg_q, n_bi[2:0]);
							end else begin
								n_retry = cfg.r1_retry_limit; n_phase = sdh_pkg::PH_CR1;
							end
						end
						sdh_pkg::PH_CR1: begin
							if (item.rx_byte[7]) begin
								n_retry = retry_q - 8'd1;
								if (n_retry != '0) act = sdh_pkg::ACT_SEND;
								else begin do_ret = 1'b1; ret_r1 = item.rx_byte; end
							end else begin
								do_ret = 1'b1; ret_r1 = item.rx_byte;
							end
						end
						sdh_pkg::PH_R7, sdh_pkg::PH_OCR: begin
							n_reply[bi_q[1:0]] = item.rx_byte;
							n_bi = bi_q + 10'd1;
							if (n_bi < 10'd4) act = sdh_pkg::ACT_SEND;
							else if (phase_q == sdh_pkg::PH_OCR) begin
								n_new_kind = n_reply[0][6] ? sdh_pkg::CT_SD2BLK : sdh_pkg::CT_SD2B;
								act = sdh_pkg::ACT_FINISH_INIT;
							end else if (n_reply[2] == 8'h01 && n_reply[3] == 8'hAA) begin
								if (init_ms_q < cfg.init_timeout_ms) begin
									act = sdh_pkg::ACT_ISSUE; act_cmd = sdh_pkg::ACMD_OP_COND;
									act_arg = sdh_pkg::HCS_ARG; act_k = sdh_pkg::K_A41V2;
								end else begin
									n_new_kind = sdh_pkg::CT_NONE; act = sdh_pkg::ACT_FINISH_INIT;
								end
							end else begin
								n_new_kind = sdh_pkg::CT_NONE; act = sdh_pkg::ACT_FINISH_INIT;
							end
						end
						sdh_pkg::PH_DDONE: begin
							if (req_q == sdh_pkg::REQ_INIT) begin
								n_op_ok = (card_kind_q != sdh_pkg::CT_NONE);
								if (n_op_ok) begin n_speed = 1'b1; n_ready = 1'b1; end
							end
							act = sdh_pkg::ACT_DONE;
						end
						sdh_pkg::PH_TOKEN: begin
							if (item.rx_byte == sdh_pkg::IDLE_BYTE
									&& elapsed_q < cfg.token_timeout_ms) begin
								act = sdh_pkg::ACT_SEND;
							end else if (item.rx_byte != sdh_pkg::TOKEN_START) begin
								n_op_ok = 1'b0; act = sdh_pkg::ACT_FINISH;
							end else begin
								n_bi = '0; n_phase = sdh_pkg::PH_RDATA; act = sdh_pkg::ACT_SEND;
							end
						end
						sdh_pkg::PH_RDATA: begin
							act = sdh_pkg::ACT_SEND;
							n_bi = bi_q + 10'd1;
							if (req_q == sdh_pkg::REQ_READ) begin
								pre_valid = 1'b1;
								pre_res.kind = sdh_pkg::KIND_DATA;
								pre_res.chip_select_n = cs_n_q;
								pre_res.fast_clock = speed_q;
								pre_res.data_byte = item.rx_byte;
								pre_res.last = (bi_q == 10'(sdh_pkg::BLOCK_BYTES - 1));
								pre_res.card_type = card_kind_q;
								if (32'(n_bi) >= 32'(sdh_pkg::BLOCK_BYTES)) begin
									n_bi = '0; n_phase = sdh_pkg::PH_RCRC;
								end
							end else begin
								n_csd[bi_q[3:0]] = item.rx_byte;
								if (n_bi >= 10'd16) begin n_bi = '0; n_phase = sdh_pkg::PH_RCRC; end
							end
						end
						sdh_pkg::PH_RCRC: begin
							n_bi = bi_q + 10'd1;
							if (n_bi < 10'd2) act = sdh_pkg::ACT_SEND;
							else if (req_q == sdh_pkg::REQ_READ) begin
								n_cur = cur_q + 32'd1; n_blocks = blocks_q - 16'd1;
								if (n_blocks == '0) begin
									n_op_ok = 1'b1; act = sdh_pkg::ACT_FINISH;
								end else begin
									act = sdh_pkg::ACT_ISSUE; act_cmd = sdh_pkg::CMD_READ1;
									act_k = sdh_pkg::K_CMD17;
									act_arg = (card_kind_q == sdh_pkg::CT_SD2BLK) ? n_cur
										: (n_cur << 9);
								end
							end else begin
								n_cap = sdh_pkg::decode_csd(csd_q);
								n_op_ok = 1'b1; act = sdh_pkg::ACT_FINISH;
							end
						end
						sdh_pkg::PH_WREADY: begin
							if (item.rx_byte == sdh_pkg::IDLE_BYTE) begin
								n_phase = sdh_pkg::PH_WTOKEN; act = sdh_pkg::ACT_SEND;
								act_tx = sdh_pkg::TOKEN_START;
							end else if (elapsed_q < cfg.write_timeout_ms) act = sdh_pkg::ACT_SEND;
							else act = sdh_pkg::ACT_WEND;
						end
						sdh_pkg::PH_WTOKEN: begin
							n_bi = '0; n_phase = sdh_pkg::PH_WNEED; act = sdh_pkg::ACT_NEED;
						end
						sdh_pkg::PH_WDATA: begin
							n_bi = bi_q + 10'd1;
							if (32'(n_bi) < 32'(sdh_pkg::BLOCK_BYTES)) begin
								n_phase = sdh_pkg::PH_WNEED; act = sdh_pkg::ACT_NEED;
								act_last = (n_bi == 10'(sdh_pkg::BLOCK_BYTES - 1));
							end else begin
								n_bi = '0; n_phase = sdh_pkg::PH_WCRC; act = sdh_pkg::ACT_SEND;
							end
						end
						sdh_pkg::PH_WCRC: begin
							n_bi = bi_q + 10'd1;
							act = sdh_pkg::ACT_SEND;
							if (!(n_bi < 10'd2)) n_phase = sdh_pkg::PH_WRESP;
						end
						sdh_pkg::PH_WRESP: begin
							if ((item.rx_byte & 8'h1F) == sdh_pkg::RESP_OK) begin
								n_cur = cur_q + 32'd1; n_blocks = blocks_q - 16'd1;
								if (n_blocks == '0) act = sdh_pkg::ACT_WEND;
								else begin
									act = sdh_pkg::ACT_ISSUE; act_cmd = sdh_pkg::CMD_WRITE1;
									act_k = sdh_pkg::K_CMD24;
									act_arg = (card_kind_q == sdh_pkg::CT_SD2BLK) ? n_cur
										: (n_cur << 9);
								end
							end else act = sdh_pkg::ACT_WEND;
						end
						sdh_pkg::PH_WFINAL: begin
							if (item.rx_byte != sdh_pkg::IDLE_BYTE
									&& elapsed_q < cfg.write_timeout_ms) begin
								act = sdh_pkg::ACT_SEND;
							end else begin
								n_op_ok = (blocks_q == '0); act = sdh_pkg::ACT_FINISH;
							end
						end
						sdh_pkg::PH_SSEL: begin
							n_elapsed = '0; n_phase = sdh_pkg::PH_SWAIT; act = sdh_pkg::ACT_SEND;
						end
						sdh_pkg::PH_SWAIT: begin
							if (item.rx_byte == sdh_pkg::IDLE_BYTE) begin
								n_op_ok = 1'b1; act = sdh_pkg::ACT_FINISH;
							end else if (elapsed_q < cfg.ready_timeout_ms) act = sdh_pkg::ACT_SEND;
							else begin
								n_op_ok = 1'b0; n_cs_n = 1'b1; n_phase = sdh_pkg::PH_SFAIL;
								act = sdh_pkg::ACT_SEND;
							end
						end
						sdh_pkg::PH_SFAIL: act = sdh_pkg::ACT_FINISH;
						default: act = sdh_pkg::ACT_NONE;
					endcase
				end
			endcase
		end

		// Command return: ACMD prefix step, then dispatch on the continuation
		if (do_ret) begin
			n_in_app = 1'b0;
			if (in_app_q && ret_r1 <= 8'd1) begin
				n_cs_n = 1'b1; n_phase = sdh_pkg::PH_CDESEL; act = sdh_pkg::ACT_SEND;
			end else begin
				case (cont_q)
					sdh_pkg::K_CMD0: begin
						if (ret_r1 == 8'd1) begin
							n_init_ms = '0;
							act = sdh_pkg::ACT_ISSUE; act_cmd = sdh_pkg::CMD_IF_COND;
							act_arg = sdh_pkg::IF_COND_ARG; act_k = sdh_pkg::K_CMD8;
						end else begin
							n_new_kind = sdh_pkg::CT_NONE; act = sdh_pkg::ACT_FINISH_INIT;
						end
					end
					sdh_pkg::K_CMD8: begin
						if (ret_r1 == 8'd1) begin
							n_bi = '0; n_phase = sdh_pkg::PH_R7; act = sdh_pkg::ACT_SEND;
						end else begin
							act = sdh_pkg::ACT_ISSUE; act_cmd = sdh_pkg::ACMD_OP_COND;
							act_k = sdh_pkg::K_PROBE;
						end
					end
					sdh_pkg::K_A41V2: begin
						if (ret_r1 == 8'd0) begin
							act = sdh_pkg::ACT_ISSUE; act_cmd = sdh_pkg::CMD_READ_OCR;
							act_k = sdh_pkg::K_CMD58;
						end else if (init_ms_q < cfg.init_timeout_ms) begin
							act = sdh_pkg::ACT_ISSUE; act_cmd = sdh_pkg::ACMD_OP_COND;
							act_arg = sdh_pkg::HCS_ARG; act_k = sdh_pkg::K_A41V2;
						end else begin
							n_new_kind = sdh_pkg::CT_NONE; act = sdh_pkg::ACT_FINISH_INIT;
						end
					end
					sdh_pkg::K_CMD58: begin
						if (ret_r1 == 8'd0) begin
							n_bi = '0; n_phase = sdh_pkg::PH_OCR; act = sdh_pkg::ACT_SEND;
						end else begin
							n_new_kind = sdh_pkg::CT_NONE; act = sdh_pkg::ACT_FINISH_INIT;
						end
					end
					sdh_pkg::K_PROBE, sdh_pkg::K_POLL1: begin
						if (cont_q == sdh_pkg::K_PROBE) begin
							if (ret_r1 <= 8'd1) begin
								n_new_kind = sdh_pkg::CT_SD1; n_poll_cmd = sdh_pkg::ACMD_OP_COND;
							end else begin
								n_new_kind = sdh_pkg::CT_MMC; n_poll_cmd = sdh_pkg::CMD_OP_MMC;
							end
						end
						if (cont_q == sdh_pkg::K_POLL1 && ret_r1 == 8'd0) begin
							act = sdh_pkg::ACT_ISSUE; act_cmd = sdh_pkg::CMD_BLOCKLEN;
							act_arg = 32'(sdh_pkg::BLOCK_BYTES); act_k = sdh_pkg::K_CMD16;
						end else if (init_ms_q < cfg.init_timeout_ms) begin
							act = sdh_pkg::ACT_ISSUE; act_cmd = n_poll_cmd;
							act_k = sdh_pkg::K_POLL1;
						end else begin
							n_new_kind = sdh_pkg::CT_NONE; act = sdh_pkg::ACT_FINISH_INIT;
						end
					end
					sdh_pkg::K_CMD16: begin
						if (ret_r1 != 8'd0) n_new_kind = sdh_pkg::CT_NONE;
						act = sdh_pkg::ACT_FINISH_INIT;
					end
					sdh_pkg::K_CMD17, sdh_pkg::K_CMD9: begin
						if (ret_r1 == 8'd0) begin
							n_elapsed = '0; n_phase = sdh_pkg::PH_TOKEN; act = sdh_pkg::ACT_SEND;
						end else begin
							n_op_ok = 1'b0; act = sdh_pkg::ACT_FINISH;
						end
					end
					default: begin
						if (ret_r1 == 8'd0) begin
							n_elapsed = '0; n_phase = sdh_pkg::PH_WREADY; act = sdh_pkg::ACT_SEND;
						end else act = sdh_pkg::ACT_WEND;
					end
				endcase
			end
		end

		// Apply the chosen action
		act_res.kind = sdh_pkg::KIND_TX;
		act_res.tx_byte = act_tx;
		case (act)
			sdh_pkg::ACT_ISSUE: begin
				n_pending = act_cmd; n_arg = act_arg; n_cont = act_k;
				n_in_app = act_cmd[7]; n_cs_n = 1'b1; n_phase = sdh_pkg::PH_CDESEL;
				act_res.tx_byte = sdh_pkg::IDLE_BYTE;
			end
			sdh_pkg::ACT_FINISH_INIT: begin
				n_card_kind = n_new_kind; n_cs_n = 1'b1; n_phase = sdh_pkg::PH_DDONE;
				act_res.tx_byte = sdh_pkg::IDLE_BYTE;
			end
			sdh_pkg::ACT_FINISH: begin
				n_cs_n = 1'b1; n_phase = sdh_pkg::PH_DDONE;
				act_res.tx_byte = sdh_pkg::IDLE_BYTE;
			end
			sdh_pkg::ACT_WEND: begin
				n_elapsed = '0; n_phase = sdh_pkg::PH_WFINAL;
				act_res.tx_byte = sdh_pkg::IDLE_BYTE;
			end
			sdh_pkg::ACT_DONE: begin
				n_phase = sdh_pkg::PH_IDLE;
				act_res.kind = sdh_pkg::KIND_DONE;
				act_res.tx_byte = '0;
				act_res.last = 1'b1;
				act_res.status = !n_op_ok;
				act_res.sector_count = (n_req == sdh_pkg::REQ_CAP && n_op_ok) ? n_cap : '0;
			end
			sdh_pkg::ACT_NEED: begin
				act_res.kind = sdh_pkg::KIND_NEED;
				act_res.tx_byte = '0;
				act_res.last = act_last;
			end
			default: ;
		endcase
		act_res.chip_select_n = n_cs_n;
		act_res.fast_clock = n_speed;
		act_res.card_type = n_card_kind;
	end

	// Result slots
	always_comb begin
		if (pre_valid) begin
			res0 = pre_res; res1 = act_res; res_cnt = 2'd2;
		end else begin
			res0 = act_res; res1 = act_res;
			res_cnt = (act == sdh_pkg::ACT_NONE) ? 2'd0 : 2'd1;
		end
	end

endmodule
`default_nettype wire

@@ design/sdh_outq.sv @@
// Result queue: takes up to two results a cycle, hands out one per transaction.
// Depends on sdh_pkg for the result type and depth.
`default_nettype none
module sdh_outq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [1:0]    push_cnt,
	input  wire sdh_pkg::res_t push0,
	input  wire sdh_pkg::res_t push1,
	input  wire logic          pop,
	output logic               not_empty,
	output logic               room,
	output sdh_pkg::res_t      head
);

	localparam int PW = $clog2(sdh_pkg::Q_DEPTH);

	sdh_pkg::res_t mem_q [sdh_pkg::Q_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;

	assign not_empty = (cnt_q != '0);
	// Space for the item in flight and one more, two results each
	assign room = (32'(cnt_q) <= sdh_pkg::Q_DEPTH - 4);
	assign head = mem_q[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) mem_q[wr_q] <= push0;
		if (push_cnt == 2'd2) mem_q[wr_q + PW'(1)] <= push1;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + PW'(push_cnt);
			if (pop) rd_q <= rd_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(push_cnt) - (PW+1)'(pop);
		end
	end

endmodule
`default_nettype wire

@@ design/sd_card_spi_host_engine_core.sv @@
// SD card SPI-mode host engine: top level with configuration, input register and result queue.
// Depends on sdh_pkg, sdh_if, sdh_engine and sdh_outq.
// Each input item (request, received card byte, millisecond tick or write payload byte) is
// captured in an input register and processed in the following cycle by one pass of the
// sequencer logic, which emits zero, one or two result transactions (two only for a read data
// byte, which also yields the next byte to send). The engine takes one item per cycle; the
// input channel is held off only while the eight-entry result queue is more than half full,
// so sustained rate is one item per cycle whenever results are taken at least as fast.
`default_nettype none
module sd_card_spi_host_engine_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sdh_in_if.sink     in_ch,
	sdh_out_if.source  out_ch,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	sdh_pkg::cfg_t  cfg_q;
	sdh_pkg::item_t item_s1;
	logic           valid_s1;
	logic [1:0]     res_cnt;
	sdh_pkg::res_t  res0, res1, head;
	logic           room, not_empty, pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.r1_retry_limit <= 8'd10;
			cfg_q.init_timeout_ms <= 16'd1000;
			cfg_q.ready_timeout_ms <= 16'd500;
			cfg_q.token_timeout_ms <= 16'd200;
			cfg_q.write_timeout_ms <= 16'd500;
			cfg_q.wake_byte_count <= 8'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				sdh_pkg::CFG_R1_RETRY:   cfg_q.r1_retry_limit <= cfg_data[7:0];
				sdh_pkg::CFG_INIT_TO:    cfg_q.init_timeout_ms <= cfg_data;
				sdh_pkg::CFG_READY_TO:   cfg_q.ready_timeout_ms <= cfg_data;
				sdh_pkg::CFG_TOKEN_TO:   cfg_q.token_timeout_ms <= cfg_data;
				sdh_pkg::CFG_WRITE_TO:   cfg_q.write_timeout_ms <= cfg_data;
				sdh_pkg::CFG_WAKE_BYTES: cfg_q.wake_byte_count <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = room;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= in_ch.valid && in_ch.ready;
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.op <= in_ch.op;
			item_s1.request <= in_ch.request;
			item_s1.start_sector <= in_ch.start_sector;
			item_s1.block_count <= in_ch.block_count;
			item_s1.rx_byte <= in_ch.rx_byte;
			item_s1.write_byte <= in_ch.write_byte;
		end
	end

	sdh_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item       (item_s1),
		.cfg        (cfg_q),
		.res_cnt    (res_cnt),
		.res0       (res0),
		.res1       (res1)
	);

	assign pop = out_ch.valid && out_ch.ready;

	sdh_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (res_cnt),
		.push0     (res0),
		.push1     (res1),
		.pop       (pop),
		.not_empty (not_empty),
		.room      (room),
		.head      (head)
	);

	// Result channel
	assign out_ch.valid = not_empty;
	assign out_ch.kind = head.kind;
	assign out_ch.tx_byte = head.tx_byte;
	assign out_ch.chip_select_n = head.chip_select_n;
	assign out_ch.fast_clock = head.fast_clock;
	assign out_ch.data_byte = head.data_byte;
	assign out_ch.last = head.last;
	assign out_ch.status = head.status;
	assign out_ch.card_type = head.card_type;
	assign out_ch.sector_count = head.sector_count;

endmodule
`default_nettype wire

@@ bench/tb_sd_card_spi_host_engine_core.sv @@
// Testbench for the SD card SPI host engine: a card emulator drives requests, card bytes,
// ticks and write bytes, and every result is checked against a cycle-free sequencer model.
// Depends on sdh_pkg, sdh_if and the sd_card_spi_host_engine_core design files.
`timescale 1ns / 1ps
module tb_sd_card_spi_host_engine_core;
	import sdh_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	sdh_in_if  in_ch();
	sdh_out_if out_ch();

	sd_card_spi_host_engine_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run limit
	initial begin
		#4_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sequencer model state
	// ------------------------------------------------------------------
	cfg_t        m_cfg;
	phase_t      m_ph;
	cont_t       m_cont;
	logic [2:0]  m_ct, m_nk, m_rq;
	logic        m_rdy, m_fast, m_cs_n, m_inapp, m_ok, m_doom;
	logic [7:0]  m_retry, m_pend, m_pollc;
	logic [15:0] m_el, m_init_ms, m_bidx, m_blk;
	logic [31:0] m_sect, m_arg, m_cap;
	logic [7:0]  m_reply [4];
	logic [7:0]  m_csd [16];

	res_t card_res_q[$];
	int   n_pred, n_in, n_chk, n_err;

	task model_reset();
		m_cfg = '{8'd10, 16'd1000, 16'd500, 16'd200, 16'd500, 8'd10};
		m_ph = PH_IDLE; m_cont = K_CMD0; m_ct = CT_NONE; m_nk = CT_NONE; m_rq = REQ_INIT;
		m_rdy = 0; m_fast = 0; m_cs_n = 1; m_inapp = 0; m_ok = 0; m_doom = 0;
		m_retry = 0; m_pend = 0; m_pollc = 0; m_el = 0; m_init_ms = 0; m_bidx = 0;
		m_blk = 0; m_sect = 0; m_arg = 0; m_cap = 0;
	endtask

	task emit(logic [1:0] k, logic [7:0] tx, logic [7:0] d, logic l, logic st, logic [31:0] c);
		res_t r;
		r.kind = k; r.tx_byte = tx; r.chip_select_n = m_cs_n; r.fast_clock = m_fast;
		r.data_byte = d; r.last = l; r.status = st; r.card_type = m_ct; r.sector_count = c;
		card_res_q.push_back(r);
		n_pred++;
	endtask

	task send_b(logic [7:0] b);
		emit(KIND_TX, b, 8'd0, 1'b0, 1'b0, 32'd0);
	endtask

	task req_done();
		m_ph = PH_IDLE;
		emit(KIND_DONE, 8'd0, 8'd0, 1'b1, !m_ok, (m_rq == REQ_CAP && m_ok) ? m_cap : 32'd0);
	endtask

	task deselect_finish();
		m_cs_n = 1; m_ph = PH_DDONE; send_b(IDLE_BYTE);
	endtask

	task init_finish();
		m_ct = m_nk; deselect_finish();
	endtask

	function logic [7:0] frame_at(logic [15:0] i);
		logic [5:0]  idx;
		logic [31:0] a;
		idx = m_inapp ? CMD_APP : m_pend[5:0];
		a   = m_inapp ? 32'd0 : m_arg;
		if (i == 0) return 8'h40 | {2'b00, idx};
		if (i < 5) return 8'(a >> (8 * (4 - i)));
		if (idx == CMD_GO_IDLE[5:0]) return CRC_CMD0;
		if (idx == CMD_IF_COND[5:0]) return CRC_CMD8;
		return CRC_DUMMY;
	endfunction

	task issue(logic [7:0] cmd, logic [31:0] arg, cont_t k);
		m_pend = cmd; m_arg = arg; m_cont = k; m_inapp = cmd[7];
		m_cs_n = 1; m_ph = PH_CDESEL; send_b(IDLE_BYTE);
	endtask

	function logic [31:0] block_addr();
		return (m_ct == CT_SD2BLK) ? m_sect : m_sect << 9;
	endfunction

	// Capacity from CSD: v2 layout for structure 1, v1 otherwise
	function logic [31:0] csd_sectors();
		logic [31:0] sz;
		int unsigned e;
		if (m_csd[0][7:6] == 2'd1) begin
			sz = {10'd0, m_csd[7][5:0], m_csd[8], m_csd[9]};
			return (sz + 1) << 10;
		end
		e  = m_csd[5][3:0] + {m_csd[9][1:0], m_csd[10][7]} + 2;
		sz = {20'd0, m_csd[6][1:0], m_csd[7], m_csd[8][7:6]};
		if (e >= 9) return (sz + 1) << (e - 9);
		return (sz + 1) >> (9 - e);
	endfunction

	task poll_v2();
		if (m_init_ms < m_cfg.init_timeout_ms) issue(ACMD_OP_COND, HCS_ARG, K_A41V2);
		else begin
			m_nk = CT_NONE; init_finish();
		end
	endtask

	task poll_v1();
		if (m_init_ms < m_cfg.init_timeout_ms) issue(m_pollc, 32'd0, K_POLL1);
		else begin
			m_nk = CT_NONE; init_finish();
		end
	endtask

	task read_next();
		if (m_blk == 0) begin
			m_ok = 1; deselect_finish();
		end else issue(CMD_READ1, block_addr(), K_CMD17);
	endtask

	task write_end();
		m_el = 0; m_ph = PH_WFINAL; send_b(IDLE_BYTE);
	endtask

	task write_next();
		if (m_blk == 0) write_end();
		else issue(CMD_WRITE1, block_addr(), K_CMD24);
	endtask

	// Next step after an R1 answer, by what the command was for
	task r1_dispatch(logic [7:0] r1);
		case (m_cont)
			K_CMD0: begin
				if (r1 == 1) begin
					m_init_ms = 0; issue(CMD_IF_COND, IF_COND_ARG, K_CMD8);
				end else begin
					m_nk = CT_NONE; init_finish();
				end
			end
			K_CMD8: begin
				if (r1 == 1) begin
					m_bidx = 0; m_ph = PH_R7; send_b(IDLE_BYTE);
				end else issue(ACMD_OP_COND, 32'd0, K_PROBE);
			end
			K_A41V2: begin
				if (r1 == 0) issue(CMD_READ_OCR, 32'd0, K_CMD58);
				else poll_v2();
			end
			K_CMD58: begin
				if (r1 == 0) begin
					m_bidx = 0; m_ph = PH_OCR; send_b(IDLE_BYTE);
				end else begin
					m_nk = CT_NONE; init_finish();
				end
			end
			K_PROBE: begin
				if (r1 <= 1) begin
					m_nk = CT_SD1; m_pollc = ACMD_OP_COND;
				end else begin
					m_nk = CT_MMC; m_pollc = CMD_OP_MMC;
				end
				poll_v1();
			end
			K_POLL1: begin
				if (r1 == 0) issue(CMD_BLOCKLEN, BLOCK_BYTES, K_CMD16);
				else poll_v1();
			end
			K_CMD16: begin
				if (r1 != 0) m_nk = CT_NONE;
				init_finish();
			end
			K_CMD17, K_CMD9: begin
				if (r1 == 0) begin
					m_el = 0; m_ph = PH_TOKEN; send_b(IDLE_BYTE);
				end else begin
					m_ok = 0; deselect_finish();
				end
			end
			default: begin
				if (r1 == 0) begin
					m_el = 0; m_ph = PH_WREADY; send_b(IDLE_BYTE);
				end else write_end();
			end
		endcase
	endtask

	// R1 answered: after an accepted CMD55 prefix go on to the application command itself, else dispatch
	task r1_return(logic [7:0] r1);
		if (m_inapp) begin
			m_inapp = 0;
			if (r1 <= 1) begin
				m_cs_n = 1; m_ph = PH_CDESEL; send_b(IDLE_BYTE);
				return;
			end
		end
		r1_dispatch(r1);
	endtask

	task card_byte(logic [7:0] rx);
		case (m_ph)
			PH_WAKE: begin
				m_bidx++;
				if (m_bidx < m_cfg.wake_byte_count) send_b(IDLE_BYTE);
				else issue(CMD_GO_IDLE, 32'd0, K_CMD0);
			end
			PH_CDESEL: begin
				m_cs_n = 0; m_ph = PH_CSEL; send_b(IDLE_BYTE);
			end
			PH_CSEL: begin
				m_el = 0; m_ph = PH_CWAIT; send_b(IDLE_BYTE);
			end
			PH_CWAIT: begin
				if (rx == IDLE_BYTE) begin
					m_bidx = 0; m_ph = PH_CFRAME; send_b(frame_at(16'd0));
				end else if (m_el < m_cfg.ready_timeout_ms) send_b(IDLE_BYTE);
				else begin
					m_cs_n = 1; m_ph = PH_CFAIL; send_b(IDLE_BYTE);
				end
			end
			PH_CFAIL: r1_return(IDLE_BYTE);
			PH_CFRAME: begin
				m_bidx++;
				if (m_bidx < 6) send_b(frame_at(m_bidx));
				else begin
					m_retry = m_cfg.r1_retry_limit; m_ph = PH_CR1; send_b(IDLE_BYTE);
				end
			end
			PH_CR1: begin
				if (rx[7]) m_retry--;
				if (rx[7] && m_retry != 0) send_b(IDLE_BYTE);
				else r1_return(rx);
			end
			PH_R7, PH_OCR: begin
				m_reply[m_bidx[1:0]] = rx;
				m_bidx++;
				if (m_bidx < 4) send_b(IDLE_BYTE);
				else if (m_ph == PH_OCR) begin
					m_nk = m_reply[0][6] ? CT_SD2BLK : CT_SD2B; init_finish();
				end else if (m_reply[2] == 8'h01 && m_reply[3] == IF_COND_ARG[7:0]) poll_v2();
				else begin
					m_nk = CT_NONE; init_finish();
				end
			end
			PH_DDONE: begin
				if (m_rq == REQ_INIT) begin
					m_ok = m_ct != CT_NONE;
					if (m_ok) begin
						m_fast = 1; m_rdy = 1;
					end
				end
				req_done();
			end
			PH_TOKEN: begin
				if (rx == IDLE_BYTE && m_el < m_cfg.token_timeout_ms) send_b(IDLE_BYTE);
				else if (rx != TOKEN_START) begin
					m_ok = 0; deselect_finish();
				end else begin
					m_bidx = 0; m_ph = PH_RDATA; send_b(IDLE_BYTE);
				end
			end
			PH_RDATA: begin
				if (m_rq == REQ_READ) begin
					emit(KIND_DATA, 8'd0, rx, m_bidx == BLOCK_BYTES - 1, 1'b0, 32'd0);
					m_bidx++;
					if (m_bidx >= BLOCK_BYTES) begin
						m_bidx = 0; m_ph = PH_RCRC;
					end
				end else begin
					m_csd[m_bidx[3:0]] = rx;
					m_bidx++;
					if (m_bidx >= 16) begin
						m_bidx = 0; m_ph = PH_RCRC;
					end
				end
				send_b(IDLE_BYTE);
			end
			PH_RCRC: begin
				m_bidx++;
				if (m_bidx < 2) send_b(IDLE_BYTE);
				else if (m_rq == REQ_READ) begin
					m_sect++; m_blk--; read_next();
				end else begin
					m_cap = csd_sectors(); m_ok = 1; deselect_finish();
				end
			end
			PH_WREADY: begin
				if (rx == IDLE_BYTE) begin
					m_ph = PH_WTOKEN; send_b(TOKEN_START);
				end else if (m_el < m_cfg.write_timeout_ms) send_b(IDLE_BYTE);
				else write_end();
			end
			PH_WTOKEN: begin
				m_bidx = 0; m_ph = PH_WNEED;
				emit(KIND_NEED, 8'd0, 8'd0, 1'b0, 1'b0, 32'd0);
			end
			PH_WDATA: begin
				m_bidx++;
				if (m_bidx < BLOCK_BYTES) begin
					m_ph = PH_WNEED;
					emit(KIND_NEED, 8'd0, 8'd0, m_bidx == BLOCK_BYTES - 1, 1'b0, 32'd0);
				end else begin
					m_bidx = 0; m_ph = PH_WCRC; send_b(IDLE_BYTE);
				end
			end
			PH_WCRC: begin
				m_bidx++;
				if (m_bidx >= 2) m_ph = PH_WRESP;
				send_b(IDLE_BYTE);
			end
			PH_WRESP: begin
				if (rx[4:0] == RESP_OK[4:0]) begin
					m_sect++; m_blk--; write_next();
				end else write_end();
			end
			PH_WFINAL: begin
				if (rx != IDLE_BYTE && m_el < m_cfg.write_timeout_ms) send_b(IDLE_BYTE);
				else begin
					m_ok = m_blk == 0; deselect_finish();
				end
			end
			PH_SSEL: begin
				m_el = 0; m_ph = PH_SWAIT; send_b(IDLE_BYTE);
			end
			PH_SWAIT: begin
				if (rx == IDLE_BYTE) begin
					m_ok = 1; deselect_finish();
				end else if (m_el < m_cfg.ready_timeout_ms) send_b(IDLE_BYTE);
				else begin
					m_ok = 0; m_cs_n = 1; m_ph = PH_SFAIL; send_b(IDLE_BYTE);
				end
			end
			PH_SFAIL: deselect_finish();
			default: ;
		endcase
	endtask

	task host_request(logic [2:0] rq, logic [31:0] sector, logic [15:0] count);
		m_rq = rq; m_ok = 0; m_cap = 0;
		if (rq == REQ_INIT) begin
			m_rdy = 0; m_ct = CT_NONE; m_fast = 0; m_nk = CT_NONE; m_cs_n = 1; m_bidx = 0;
			if (m_cfg.wake_byte_count == 0) issue(CMD_GO_IDLE, 32'd0, K_CMD0);
			else begin
				m_ph = PH_WAKE; send_b(IDLE_BYTE);
			end
		end else if (rq > REQ_CAP || !m_rdy) req_done();
		else begin
			m_sect = sector; m_blk = count;
			case (rq)
				REQ_READ:  read_next();
				REQ_WRITE: write_next();
				REQ_CAP:   issue(CMD_SEND_CSD, 32'd0, K_CMD9);
				default: begin
					m_cs_n = 0; m_ph = PH_SSEL; send_b(IDLE_BYTE);
				end
			endcase
		end
	endtask

	// One accepted input transaction through the model
	task predict_item(item_t it);
		case (it.op)
			OP_REQUEST: if (m_ph == PH_IDLE)
				host_request(it.request, it.start_sector, it.block_count);
			OP_RXBYTE: if (m_ph != PH_IDLE && m_ph != PH_WNEED) card_byte(it.rx_byte);
			OP_TICK: begin
				if (m_el != 16'hFFFF) m_el++;
				if (m_init_ms != 16'hFFFF) m_init_ms++;
			end
			default: if (m_ph == PH_WNEED) begin
				m_ph = PH_WDATA; send_b(it.write_byte);
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Card emulator: picks the next transaction from the model's phase
	// ------------------------------------------------------------------
	function logic [7:0] r1_answer();
		if ($urandom_range(9) < 3) return IDLE_BYTE;
		if (m_inapp) return ($urandom_range(9) != 0) ? 8'h01 : 8'h05;
		case (m_cont)
			K_CMD0:   return ($urandom_range(9) != 0) ? 8'h01 : 8'h00;
			K_CMD8:   return ($urandom_range(9) < 7) ? 8'h01 : 8'h05;
			K_A41V2:  return 8'($urandom_range(1));
			K_CMD58:  return ($urandom_range(19) != 0) ? 8'h00 : 8'h04;
			K_PROBE:  return 8'($urandom_range(2)) << 2 | 8'($urandom_range(1));
			K_POLL1:  return 8'($urandom_range(1));
			K_CMD16:  return ($urandom_range(9) != 0) ? 8'h00 : 8'h04;
			default:  return (m_doom || $urandom_range(19) == 0) ? 8'h04 : 8'h00;
		endcase
	endfunction

	function logic [7:0] card_answer();
		case (m_ph)
			PH_CWAIT, PH_WREADY, PH_WFINAL, PH_SWAIT:
				return ($urandom_range(9) < 8) ? IDLE_BYTE : 8'($urandom);
			PH_CR1: return r1_answer();
			PH_R7: begin
				if ($urandom_range(9) == 0) return 8'($urandom);
				case (m_bidx[1:0])
					2'd2: return 8'h01;
					2'd3: return IF_COND_ARG[7:0];
					default: return 8'h00;
				endcase
			end
			PH_TOKEN: begin
				if ($urandom_range(19) < 15) return TOKEN_START;
				return ($urandom_range(1) != 0) ? IDLE_BYTE : 8'($urandom);
			end
			PH_WRESP:
				return ($urandom_range(9) != 0) ? {3'($urandom), RESP_OK[4:0]} : 8'($urandom);
			default: return 8'($urandom);
		endcase
	endfunction

	task next_item(output item_t it);
		int r, pr;
		it.op = OP_RXBYTE; it.request = 3'($urandom_range(7));
		it.start_sector = $urandom; it.block_count = 16'($urandom);
		it.rx_byte = 8'($urandom); it.write_byte = 8'($urandom);
		r = $urandom_range(99);
		if (r < 2) it.op = OP_RXBYTE;
		else if (r < 4) it.op = OP_WRBYTE;
		else if (r == 4 && m_ph != PH_IDLE) it.op = OP_REQUEST;
		else if (r < 10) it.op = OP_TICK;
		else if (m_ph == PH_WNEED) it.op = OP_WRBYTE;
		else if (m_ph != PH_IDLE) it.rx_byte = card_answer();
		else begin
			// New request; rare doomed transfers carry huge counts and fail at R1
			it.op = OP_REQUEST;
			pr = $urandom_range(99);
			if (!m_rdy && pr < 75 || pr < 8) it.request = REQ_INIT;
			else if (pr < 30) it.request = REQ_READ;
			else if (pr < 55) it.request = REQ_WRITE;
			else if (pr < 72) it.request = REQ_SYNC;
			else if (pr < 94) it.request = REQ_CAP;
			else it.request = 3'($urandom_range(5, 7));
			m_doom = $urandom_range(9) == 0;
			if (!m_doom) it.block_count = 16'($urandom_range(2));
		end
	endtask

	// ------------------------------------------------------------------
	// Input driver
	// ------------------------------------------------------------------
	int burst_left;

	task put_item(item_t it);
		in_ch.valid <= 1'b1;
		in_ch.op <= it.op; in_ch.request <= it.request;
		in_ch.start_sector <= it.start_sector; in_ch.block_count <= it.block_count;
		in_ch.rx_byte <= it.rx_byte; in_ch.write_byte <= it.write_byte;
		do @(posedge clk); while (!in_ch.ready);
		n_in++;
		predict_item(it);
	endtask

	task pace();
		if (burst_left > 0) burst_left--;
		else begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(3) == 0) ? 60 : $urandom_range(1, 30);
		end
	endtask

	// Hold off until every predicted result has been seen
	task drain();
		in_ch.valid <= 1'b0;
		while (card_res_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task cfg_write(logic [2:0] idx, logic [15:0] val);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_R1_RETRY:   m_cfg.r1_retry_limit = val[7:0];
			CFG_INIT_TO:    m_cfg.init_timeout_ms = val;
			CFG_READY_TO:   m_cfg.ready_timeout_ms = val;
			CFG_TOKEN_TO:   m_cfg.token_timeout_ms = val;
			CFG_WRITE_TO:   m_cfg.write_timeout_ms = val;
			CFG_WAKE_BYTES: m_cfg.wake_byte_count = val[7:0];
			default: ;
		endcase
	endtask

	task cfg_all(logic [7:0] retry, logic [15:0] init_to, logic [15:0] rdy_to,
			logic [15:0] tok_to, logic [15:0] wr_to, logic [7:0] wake);
		cfg_write(CFG_R1_RETRY, {8'd0, retry});
		cfg_write(CFG_INIT_TO, init_to);
		cfg_write(CFG_READY_TO, rdy_to);
		cfg_write(CFG_TOKEN_TO, tok_to);
		cfg_write(CFG_WRITE_TO, wr_to);
		cfg_write(CFG_WAKE_BYTES, {8'd0, wake});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Random traffic; counts only transactions that do something
	task run_traffic(int n);
		item_t it;
		int cnt, pred_mark;
		cnt = 0;
		while (cnt < n || m_ph != PH_IDLE) begin
			next_item(it);
			pred_mark = n_pred;
			put_item(it);
			if (n_pred != pred_mark || it.op == OP_TICK) cnt++;
			pace();
		end
		drain();
	endtask

	// ------------------------------------------------------------------
	// Directed table
	// ------------------------------------------------------------------
	typedef struct {
		item_t it;
		bit    typed;
		bit    silent;
		res_t  res;
	} dir_row_t;

	localparam res_t NOT_READY = '{KIND_DONE, 8'd0, 1'b1, 1'b0, 8'd0, 1'b1, 1'b1, CT_NONE, 32'd0};
	localparam res_t NO_RES = '0;

	dir_row_t dir_tab[15] = '{
		'{'{OP_REQUEST, REQ_READ, 32'hFFFF_FFFF, 16'hFFFF, 8'h00, 8'h00}, 1, 0, NOT_READY},
		'{'{OP_REQUEST, REQ_CAP, 32'h0, 16'h1, 8'hFF, 8'hFF}, 1, 0, NOT_READY},
		'{'{OP_REQUEST, REQ_WRITE, 32'h0, 16'h0, 8'h00, 8'h00}, 1, 0, NOT_READY},
		'{'{OP_REQUEST, REQ_SYNC, 32'h8000_0001, 16'h8000, 8'h00, 8'h00}, 1, 0, NOT_READY},
		'{'{OP_REQUEST, 3'd5, 32'h0, 16'h0, 8'h00, 8'h00}, 1, 0, NOT_READY},
		'{'{OP_REQUEST, 3'd6, 32'h0, 16'h0, 8'h00, 8'h00}, 1, 0, NOT_READY},
		'{'{OP_REQUEST, 3'd7, 32'h0, 16'h0, 8'h00, 8'h00}, 1, 0, NOT_READY},
		'{'{OP_RXBYTE, REQ_INIT, 32'h0, 16'h0, 8'hFF, 8'h00}, 1, 1, NO_RES},
		'{'{OP_WRBYTE, REQ_INIT, 32'h0, 16'h0, 8'h00, 8'hFF}, 1, 1, NO_RES},
		'{'{OP_TICK, REQ_INIT, 32'h0, 16'h0, 8'h00, 8'h00}, 1, 1, NO_RES},
		'{'{OP_REQUEST, REQ_INIT, 32'h0, 16'h0, 8'h00, 8'h00}, 1, 0,
			'{KIND_TX, IDLE_BYTE, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, CT_NONE, 32'd0}},
		'{'{OP_REQUEST, REQ_READ, 32'h0, 16'h1, 8'h00, 8'h00}, 1, 1, NO_RES},
		'{'{OP_RXBYTE, REQ_INIT, 32'h0, 16'h0, 8'h00, 8'h00}, 0, 0, NO_RES},
		'{'{OP_RXBYTE, REQ_INIT, 32'h0, 16'h0, 8'hAA, 8'h00}, 0, 0, NO_RES},
		'{'{OP_RXBYTE, REQ_INIT, 32'h0, 16'h0, 8'h55, 8'h00}, 0, 0, NO_RES}
	};

	// ------------------------------------------------------------------
	// Result checker with a stall pattern of its own
	// ------------------------------------------------------------------
	int rx_cyc;
	int rx_mode;

	task check_field(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$display("%0t: %s expected %0h got %0h", $realtime, name, e, a);
			n_err++;
		end
	endtask

	always @(posedge clk) begin
		res_t e;
		if (out_ch.valid && out_ch.ready) begin
			n_chk++;
			if (card_res_q.size() == 0) begin
				$display("%0t: unexpected result kind %0d tx %0h", $realtime, out_ch.kind,
					out_ch.tx_byte);
				n_err++;
			end else begin
				e = card_res_q.pop_front();
				check_field("kind", e.kind, out_ch.kind);
				check_field("tx_byte", e.tx_byte, out_ch.tx_byte);
				check_field("chip_select_n", e.chip_select_n, out_ch.chip_select_n);
				check_field("fast_clock", e.fast_clock, out_ch.fast_clock);
				check_field("data_byte", e.data_byte, out_ch.data_byte);
				check_field("last", e.last, out_ch.last);
				check_field("status", e.status, out_ch.status);
				check_field("card_type", e.card_type, out_ch.card_type);
				check_field("sector_count", e.sector_count, out_ch.sector_count);
			end
		end
		rx_cyc++;
		if (rx_cyc % 97 == 0) rx_mode = $urandom_range(2);
		case (rx_mode)
			0: out_ch.ready <= 1'b1;
			1: out_ch.ready <= $urandom_range(1) != 0;
			default: out_ch.ready <= rx_cyc % 4 == 0;
		endcase
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int pred_mark;
		in_ch.valid = 0; in_ch.op = OP_TICK; in_ch.request = REQ_INIT;
		in_ch.start_sector = 0; in_ch.block_count = 0; in_ch.rx_byte = 0; in_ch.write_byte = 0;
		out_ch.ready = 0;
		cfg_we = 0; cfg_index = CFG_R1_RETRY; cfg_data = 0;
		n_pred = 0; n_in = 0; n_chk = 0; n_err = 0; burst_left = 0; rx_cyc = 0; rx_mode = 0;
		model_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows, with typed answers where they are obvious
		foreach (dir_tab[i]) begin
			pred_mark = n_pred;
			put_item(dir_tab[i].it);
			if (dir_tab[i].typed) begin
				repeat (n_pred - pred_mark) void'(card_res_q.pop_back());
				if (!dir_tab[i].silent) card_res_q.push_back(dir_tab[i].res);
			end
			pace();
		end
		run_traffic(130);

		// Low extremes: every timeout and limit set to 1
		cfg_all(8'd1, 16'd1, 16'd1, 16'd1, 16'd1, 8'd1);
		run_traffic(100);

		// High extremes
		cfg_all(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
		run_traffic(100);

		// Random moderate settings
		cfg_all(8'($urandom_range(1, 8)), 16'($urandom_range(1, 40)),
			16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)),
			16'($urandom_range(1, 20)), 8'($urandom_range(1, 16)));
		run_traffic(100);

		$display("Covered %0d input transactions and %0d result transactions", n_in, n_chk);
		$display("across default, minimum, maximum and random register settings");
		if (n_err == 0 && card_res_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sd_card_spi_host_engine_core.f @@
design/sdh_pkg.sv
design/sdh_if.sv
design/sdh_engine.sv
design/sdh_outq.sv
design/sd_card_spi_host_engine_core.sv
bench/tb_sd_card_spi_host_engine_core.sv
